// ===== sv/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants for the barometric compensation core.
// ----------------------------------------------------------------------------
package bptc_pkg;

   // field widths
   localparam int RAW_W      = 20;
   localparam int TF_W       = 26;
   localparam int TC_W       = 16;
   localparam int PA_W       = 24;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TEMP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_C = 2'd3;

   // compensation constants
   localparam int TFINE_OFFSET = 128000;
   localparam int DIV_SCALE    = 3125;
   localparam int RAW_FULL     = 1048576;
   localparam logic [PA_W-1:0] P_MAX = 24'hFF_FFFF;

   // divider depth, one quotient bit per stage
   localparam int DIV_STEPS = 64;

   localparam int DEF_QUEUE_DEPTH = 4;

   // unpacked calibration words
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   // transaction handed from front to back
   typedef struct packed {
      logic signed [TF_W-1:0] tfine;
      logic signed [TC_W-1:0] tcenti;
      logic        [RAW_W-1:0] raw_press;
   } tmp_item_type;

endpackage

// ===== sv/bptc_front.sv =====
// ----------------------------------------------------------------------------
// bptc_front
// Accepts raw readings and computes fine and centi-degree temperature.
// ----------------------------------------------------------------------------
module bptc_front
   import bptc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cal_type            cal,
   input  logic               in_push,
   input  logic [RAW_W-1:0]   in_raw_t,
   input  logic [RAW_W-1:0]   in_raw_p,
   input  logic               q_full,
   output logic               q_push,
   output tmp_item_type       q_item
);

   logic                     adv;
   logic [3:0]               vld_ff;
   logic signed [17:0]       d1_ff, d2_ff;
   logic signed [17:0]       d1_in, d2_in;
   logic signed [33:0]       m1_ff;
   logic signed [35:0]       sq_ff;
   logic signed [22:0]       v1a_ff;
   logic signed [37:0]       m3_ff;
   logic signed [TF_W-1:0]   tf_ff;
   logic [RAW_W-1:0]         rp1_ff, rp2_ff, rp3_ff, rp4_ff;
   logic signed [28:0]       t5;
   logic signed [20:0]       tcw;
   logic signed [TC_W-1:0]   tcs;

   assign adv = !q_full;

   // raw differences against t1
   assign d1_in = $signed({1'b0, in_raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
   assign d2_in = $signed({2'b00, in_raw_t[19:4]}) - $signed({2'b00, cal.t1});

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_push};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         rp1_ff <= in_raw_p;
         m1_ff  <= 34'(d1_ff) * 34'(cal.t2);
         sq_ff  <= 36'(d2_ff) * 36'(d2_ff);
         rp2_ff <= rp1_ff;
         v1a_ff <= 23'(m1_ff >>> 11);
         m3_ff  <= 38'($signed({1'b0, sq_ff[32:12]})) * 38'(cal.t3);
         rp3_ff <= rp2_ff;
         tf_ff  <= TF_W'(v1a_ff) + TF_W'(m3_ff >>> 14);
         rp4_ff <= rp3_ff;
      end
   end

   // centi-degree rounding and clamp
   assign t5  = 29'(tf_ff) * 29'sd5 + 29'sd128;
   assign tcw = 21'(t5 >>> 8);
   always_comb begin
      priority if (tcw > 21'sd32767) begin
         tcs = 16'sh7FFF;
      end else if (tcw < -21'sd32768) begin
         tcs = 16'sh8000;
      end else begin
         tcs = 16'(tcw);
      end
   end

   assign q_push           = vld_ff[3] && adv;
   assign q_item.tfine     = tf_ff;
   assign q_item.tcenti    = tcs;
   assign q_item.raw_press = rp4_ff;

endmodule

// ===== sv/bptc_queue.sv =====
// ----------------------------------------------------------------------------
// bptc_queue
// Short queue of temperature results between front and back.
// ----------------------------------------------------------------------------
module bptc_queue
   import bptc_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tmp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output tmp_item_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tmp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/bptc_back.sv =====
// ----------------------------------------------------------------------------
// bptc_back
// Pressure compensation pipeline with a bit-per-stage signed divider.
// ----------------------------------------------------------------------------
module bptc_back
   import bptc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cal_type             cal,
   input  logic                q_empty,
   input  tmp_item_type        q_item,
   output logic                q_pop,
   output logic                out_empty,
   input  logic                out_pop,
   output logic signed [TC_W-1:0] out_tc,
   output logic [PA_W-1:0]     out_pa,
   output logic                out_inval
);

   localparam int PRE  = 6;
   localparam int POST = 6;
   localparam int NST  = PRE + DIV_STEPS + POST;

   typedef struct packed {
      logic [30:0]     rem;
      logic [63:0]     nq;
      logic [30:0]     mb;
      logic            neg;
      logic            zero;
      logic [TC_W-1:0] tc;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      logic [31:0]   r2;
      logic          ge;
      div_stage_type o;
      r2     = {s.rem, s.nq[63]};
      ge     = (r2 >= {1'b0, s.mb});
      o      = s;
      o.rem  = ge ? 31'(r2 - {1'b0, s.mb}) : 31'(r2);
      o.nq   = {s.nq[62:0], ge};
      return o;
   endfunction

   logic               adv;
   logic [NST-1:0]     vld_ff;

   logic signed [26:0] v;
   logic signed [53:0] vsq_ff;
   logic signed [42:0] vp5_ff, vp2_ff;
   logic [63:0]        a6_ff, a3_ff;
   logic signed [42:0] vp5b_ff, vp2b_ff;
   logic [63:0]        v2_ff, x_ff, y_ff, pn_ff, num_ff;
   logic signed [30:0] dv_ff;
   logic [RAW_W:0]     nraw;
   logic [TC_W-1:0]    tc1_ff, tc2_ff, tc3_ff, tc4_ff, tc5_ff;
   logic [RAW_W-1:0]   rp1_ff, rp2_ff, rp3_ff;
   div_stage_type      ds_ff [DIV_STEPS+1];

   logic [63:0]        p_ff, p2_ff, p3_ff, p4_ff, pq_ff, m9_ff;
   logic [63:0]        v2b_ff, v2c_ff, v2d_ff, ll_ff, prod_ff, sum_ff;
   logic [31:0]        cr_ff;
   logic [4:0]         zero_ff;
   logic [TC_W-1:0]    tcq_ff [5];
   logic [63:0]        r;
   logic [TC_W-1:0]    tc_out_ff;
   logic [PA_W-1:0]    pa_out_ff;
   logic               inval_out_ff;

   // one global advance; output register is the last stage
   assign adv       = !vld_ff[NST-1] || out_pop;
   assign q_pop     = adv && !q_empty;
   assign out_empty = !vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], q_pop};
      end
   end

   assign v    = 27'(q_item.tfine) - 27'sd128000;
   assign nraw = (RAW_W+1)'(RAW_FULL) - {1'b0, rp3_ff};

   // divisor and dividend build-up
   always_ff @(posedge clock) begin
      if (adv) begin
         vsq_ff  <= 54'(v) * 54'(v);
         vp5_ff  <= 43'(v) * 43'(cal.p5);
         vp2_ff  <= 43'(v) * 43'(cal.p2);
         tc1_ff  <= q_item.tcenti;
         rp1_ff  <= q_item.raw_press;

         a6_ff   <= 64'(vsq_ff) * 64'(cal.p6);
         a3_ff   <= 64'(vsq_ff) * 64'(cal.p3);
         vp5b_ff <= vp5_ff;
         vp2b_ff <= vp2_ff;
         tc2_ff  <= tc1_ff;
         rp2_ff  <= rp1_ff;

         v2_ff   <= a6_ff + (64'(vp5b_ff) << 17) + (64'(cal.p4) << 35);
         x_ff    <= 64'($signed(a3_ff) >>> 8) + (64'(vp2b_ff) << 12) + 64'h0000_8000_0000_0000;
         tc3_ff  <= tc2_ff;
         rp3_ff  <= rp2_ff;

         y_ff    <= x_ff * {48'd0, cal.p1};
         pn_ff   <= ({43'd0, nraw} << 31) - v2_ff;
         tc4_ff  <= tc3_ff;

         dv_ff   <= 31'($signed(y_ff) >>> 33);
         num_ff  <= pn_ff * 64'(DIV_SCALE);
         tc5_ff  <= tc4_ff;

         ds_ff[0].rem  <= '0;
         ds_ff[0].nq   <= num_ff[63] ? 64'(-num_ff) : num_ff;
         ds_ff[0].mb   <= dv_ff[30] ? 31'(-dv_ff) : 31'(dv_ff);
         ds_ff[0].neg  <= num_ff[63] ^ dv_ff[30];
         ds_ff[0].zero <= (dv_ff == '0);
         ds_ff[0].tc   <= tc5_ff;
      end
   end

   // divider stages
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            ds_ff[k+1] <= div_step(ds_ff[k]);
         end
      end
   end

   // post-division correction terms
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff       <= ds_ff[DIV_STEPS].neg ? 64'(-ds_ff[DIV_STEPS].nq) : ds_ff[DIV_STEPS].nq;
         zero_ff[0] <= ds_ff[DIV_STEPS].zero;
         tcq_ff[0]  <= ds_ff[DIV_STEPS].tc;

         pq_ff      <= 64'($signed(p_ff) >>> 13);
         m9_ff      <= 64'(cal.p9) * 64'($signed(p_ff) >>> 13);
         v2b_ff     <= 64'(cal.p8) * p_ff;
         p2_ff      <= p_ff;
         zero_ff[1] <= zero_ff[0];
         tcq_ff[1]  <= tcq_ff[0];

         ll_ff      <= {32'd0, m9_ff[31:0]} * {32'd0, pq_ff[31:0]};
         cr_ff      <= 32'(m9_ff[31:0] * pq_ff[63:32]) + 32'(m9_ff[63:32] * pq_ff[31:0]);
         v2c_ff     <= v2b_ff;
         p3_ff      <= p2_ff;
         zero_ff[2] <= zero_ff[1];
         tcq_ff[2]  <= tcq_ff[1];

         prod_ff    <= ll_ff + {cr_ff, 32'd0};
         v2d_ff     <= v2c_ff;
         p4_ff      <= p3_ff;
         zero_ff[3] <= zero_ff[2];
         tcq_ff[3]  <= tcq_ff[2];

         sum_ff     <= p4_ff + 64'($signed(prod_ff) >>> 25) + 64'($signed(v2d_ff) >>> 19);
         zero_ff[4] <= zero_ff[3];
         tcq_ff[4]  <= tcq_ff[3];
      end
   end

   // final scaling and saturation into the output register
   assign r = 64'($signed(sum_ff) >>> 8) + (64'(cal.p7) << 4);

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_out_ff    <= tcq_ff[4];
         inval_out_ff <= zero_ff[4];
         priority if (zero_ff[4] || r[63]) begin
            pa_out_ff <= '0;
         end else if (|r[62:32]) begin
            pa_out_ff <= P_MAX;
         end else begin
            pa_out_ff <= r[31:8];
         end
      end
   end

   assign out_tc    = $signed(tc_out_ff);
   assign out_pa    = pa_out_ff;
   assign out_inval = inval_out_ff;

endmodule

// ===== sv/baro_temp_pressure_compensation_core.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_push/req_full  raw temperature, raw pressure
//  rsp_      out        rsp_pop/rsp_empty  centi-degrees, pascals, invalid flag
//  csr_      in         csr_wr_en          index, 64-bit write data
//
//  one transaction per cycle sustained while responses are popped; a reading
//  passes front, queue, then back (including the one-bit-per-stage divider)
//  the back pipeline advances as a whole whenever its output register is
//  free or being popped; the queue lets the front keep taking readings
//  synchronous reset clears pipeline valids, queue and calibration registers
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core
   import bptc_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [RAW_W-1:0]        req_raw_temperature,
   input  logic [RAW_W-1:0]        req_raw_pressure,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic signed [TC_W-1:0]  rsp_temperature_centi,
   output logic [PA_W-1:0]         rsp_pressure_pascal,
   output logic                    rsp_pressure_invalid,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [47:0]  cal_temp_ff;
   logic [63:0]  cal_press_a_ff;
   logic [63:0]  cal_press_b_ff;
   logic [15:0]  cal_press_c_ff;
   cal_type      cal;
   logic         q_push, q_full, q_pop, q_empty;
   tmp_item_type q_in, q_out;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_wdata;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_wdata;
            CSR_CAL_PRESS_C: cal_press_c_ff <= csr_wdata[15:0];
            default:         cal_press_c_ff <= cal_press_c_ff;
         endcase
      end
   end

   // unpack calibration words
   assign cal.t1 = cal_temp_ff[15:0];
   assign cal.t2 = $signed(cal_temp_ff[31:16]);
   assign cal.t3 = $signed(cal_temp_ff[47:32]);
   assign cal.p1 = cal_press_a_ff[15:0];
   assign cal.p2 = $signed(cal_press_a_ff[31:16]);
   assign cal.p3 = $signed(cal_press_a_ff[47:32]);
   assign cal.p4 = $signed(cal_press_a_ff[63:48]);
   assign cal.p5 = $signed(cal_press_b_ff[15:0]);
   assign cal.p6 = $signed(cal_press_b_ff[31:16]);
   assign cal.p7 = $signed(cal_press_b_ff[47:32]);
   assign cal.p8 = $signed(cal_press_b_ff[63:48]);
   assign cal.p9 = $signed(cal_press_c_ff);

   assign req_full = q_full;

   bptc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cal      (cal),
      .in_push  (req_push),
      .in_raw_t (req_raw_temperature),
      .in_raw_p (req_raw_pressure),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_in)
   );

   bptc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_out)
   );

   bptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal),
      .q_empty   (q_empty),
      .q_item    (q_out),
      .q_pop     (q_pop),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_tc    (rsp_temperature_centi),
      .out_pa    (rsp_pressure_pascal),
      .out_inval (rsp_pressure_invalid)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the barometric compensation core against an in-bench predictor of
// the 64-bit integer scheme, over several calibration sets, with random
// bursts on the request side and a stall pattern on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   import bptc_pkg::*;

   // expected compensated reading
   typedef struct {
      logic signed [TC_W-1:0] tcenti;
      logic [PA_W-1:0]        pascal;
      logic                   invalid;
   } reading_type;

   // scoreboard: predicts each reading and matches it against the core output
   class comp_scoreboard;
      logic [47:0] cal_t;
      logic [63:0] cal_a;
      logic [63:0] cal_b;
      logic [15:0] cal_c;
      reading_type pending[$];
      int          mismatches;

      function new();
         cal_t = '0; cal_a = '0; cal_b = '0; cal_c = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
         case (idx)
            CSR_CAL_TEMP:    cal_t = val[47:0];
            CSR_CAL_PRESS_A: cal_a = val;
            CSR_CAL_PRESS_B: cal_b = val;
            CSR_CAL_PRESS_C: cal_c = val[15:0];
            default: ;
         endcase
      endfunction

      // truncating division, min by -1 wraps
      function logic signed [63:0] div_trunc(logic signed [63:0] a, logic signed [63:0] b);
         logic [63:0] ma, mb, q;
         ma = a[63] ? -a : a;
         mb = b[63] ? -b : b;
         if (mb == 0) return 0;
         q = ma / mb;
         return (a[63] != b[63]) ? -q : q;
      endfunction

      function void note_request(logic [19:0] rt, logic [19:0] rp);
         logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic signed [63:0] d, v1, v2, tf, tc, p, pa;
         reading_type r;
         t1 = {48'd0, cal_t[15:0]};
         t2 = $signed(cal_t[31:16]);
         t3 = $signed(cal_t[47:32]);
         p1 = {48'd0, cal_a[15:0]};
         p2 = $signed(cal_a[31:16]);
         p3 = $signed(cal_a[47:32]);
         p4 = $signed(cal_a[63:48]);
         p5 = $signed(cal_b[15:0]);
         p6 = $signed(cal_b[31:16]);
         p7 = $signed(cal_b[47:32]);
         p8 = $signed(cal_b[63:48]);
         p9 = $signed(cal_c);
         // fine temperature
         d  = (64'(rt) >> 3) - (t1 <<< 1);
         v1 = (d * t2) >>> 11;
         d  = (64'(rt) >> 4) - t1;
         v2 = (((d * d) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         tc = (tf * 5 + 128) >>> 8;
         if (tc < -32768) tc = -32768;
         else if (tc > 32767) tc = 32767;
         r.tcenti = tc[15:0];
         r.pascal = '0;
         r.invalid = 1'b0;
         // pressure
         v1 = tf - TFINE_OFFSET;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) <<< 17);
         v2 = v2 + (p4 <<< 35);
         v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
         v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            r.invalid = 1'b1;
         end else begin
            p  = RAW_FULL - 64'(rp);
            p  = div_trunc(((p <<< 31) - v2) * DIV_SCALE, v1);
            v2 = (p8 * p) >>> 19;
            v1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
            p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            pa = div_trunc(p, 256);
            if (pa < 0) r.pascal = '0;
            else if (pa > 64'(P_MAX)) r.pascal = P_MAX;
            else r.pascal = pa[23:0];
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic signed [15:0] tcv, logic [23:0] pav, logic inv);
         reading_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response t=%0d p=%0d i=%0b", tcv, pav, inv);
            return;
         end
         e = pending.pop_front();
         if (e.tcenti !== tcv || e.pascal !== pav || e.invalid !== inv) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp t=%0d p=%0d i=%0b act t=%0d p=%0d i=%0b",
                        e.tcenti, e.pascal, e.invalid, tcv, pav, inv);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [RAW_W-1:0] req_raw_temperature = '0;
   logic [RAW_W-1:0] req_raw_pressure = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [TC_W-1:0] rsp_temperature_centi;
   logic [PA_W-1:0] rsp_pressure_pascal;
   logic rsp_pressure_invalid;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   comp_scoreboard sb = new();
   bit stall_on = 1'b1;

   baro_temp_pressure_compensation_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: sample at rising edge, stall pattern set at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_response(rsp_temperature_centi, rsp_pressure_pascal, rsp_pressure_invalid);
   end

   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 37;
      if (!stall_on) rsp_pop <= 1'b1;
      else if (stall_phase < 12) rsp_pop <= ($urandom_range(0, 3) != 0);
      else if (stall_phase < 20) rsp_pop <= 1'b1;
      else rsp_pop <= ($urandom_range(0, 2) == 0);
   end

   task automatic push_reading(logic [19:0] rt, logic [19:0] rp);
      req_push <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure <= rp;
      do @(posedge clock); while (req_full);
      sb.note_request(rt, rp);
      @(negedge clock);
   endtask

   task automatic idle_req(int n);
      req_push <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // write enable stays high across back-to-back writes; load_cal drops it
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic load_cal(logic [47:0] t, logic [63:0] a, logic [63:0] b, logic [15:0] c);
      write_reg(CSR_CAL_TEMP, {16'd0, t});
      write_reg(CSR_CAL_PRESS_A, a);
      write_reg(CSR_CAL_PRESS_B, b);
      write_reg(CSR_CAL_PRESS_C, {48'd0, c});
      csr_wr_en <= 1'b0;
   endtask

   // typical factory calibration with small random spread
   function automatic logic [15:0] jit(int v);
      return 16'(v + $signed($urandom_range(0, 200)) - 100);
   endfunction

   task automatic load_typical();
      load_cal({jit(-1000), jit(26435), jit(27504)},
               {jit(2855), jit(-3024), jit(-10685), jit(36477)},
               {jit(-7), jit(15500), jit(-14600), jit(140)},
               jit(6000));
   endtask

   task automatic random_phase(int n, bit typical);
      int sent, burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if (typical)
               push_reading(20'($urandom_range(400000, 620000)),
                            20'($urandom_range(200000, 450000)));
            else
               push_reading(20'($urandom), 20'($urandom));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 15));
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // all-zero calibration: divisor zero, invalid flag
      push_reading('0, '0);
      push_reading(20'hFFFFF, 20'hFFFFF);
      drain();
      // typical calibration, field extremes
      load_typical();
      push_reading('0, '0);
      push_reading(20'hFFFFF, 20'hFFFFF);
      push_reading('0, 20'hFFFFF);
      push_reading(20'hFFFFF, '0);
      push_reading(20'd519888, 20'd415148);
      push_reading(20'h55555, 20'hAAAAA);
      push_reading(20'hAAAAA, 20'h55555);
      drain();
      // extreme calibration words: saturation both ways
      load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h8000}} | 64'hFFFF,
               {4{16'h7FFF}}, 16'h7FFF);
      push_reading(20'hFFFFF, '0);
      push_reading('0, 20'hFFFFF);
      push_reading(20'h80000, 20'h80000);
      drain();
      load_cal({16'h8000, 16'h8000, 16'h0000}, {4{16'h7FFF}},
               {4{16'h8000}}, 16'h8000);
      push_reading(20'hFFFFF, 20'hFFFFF);
      push_reading('0, '0);
      push_reading(20'h12345, 20'h6789A);
      drain();
      load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      push_reading(20'hFFFFF, '0);
      push_reading('0, 20'hFFFFF);
      drain();
      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 2 == 0) load_typical();
         else load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom));
         stall_on = (ph != 3);
         random_phase(215, ph % 2 == 0);
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
